// File: src/firq15_pkg.sv
// shared types and constants for the q15 fir filter
`default_nettype none

package firq15_pkg;

  // sample, coefficient, index, accumulator and action widths
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 4;
  localparam int ACC_W    = 32;
  localparam int ACT_W    = 2;

  // rounding: add half an lsb of the output, then drop the fraction bits
  localparam int FRAC_BITS = 15;
  localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(1) << (FRAC_BITS - 1);

  // action codes carried in tuser
  typedef enum logic [ACT_W-1:0] {
    ACT_FILTER = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_LOAD   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_t;

  // controls from the sequencer to the tap cells
  typedef struct packed {
    logic head_load;  // cell 0 takes the new sample
    logic shift;      // history moves one cell down the chain
    logic mul;        // every cell captures its product
    logic fill;       // every cell takes the fill value
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: src/firq15_tap_cell.sv
// one tap of the filter: a data word, its coefficient, a product and a partial sum
`default_nettype none

module firq15_tap_cell (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   load,
  input  wire logic                                   fill,
  input  wire logic                                   mul,
  input  wire logic                                   coef_we,
  input  wire logic signed [firq15_pkg::SAMPLE_W-1:0] coef_in,
  input  wire logic signed [firq15_pkg::SAMPLE_W-1:0] data_in,
  input  wire logic signed [firq15_pkg::SAMPLE_W-1:0] fill_value,
  input  wire logic        [firq15_pkg::ACC_W-1:0]    sum_in,
  output logic signed      [firq15_pkg::SAMPLE_W-1:0] data_out,
  output logic             [firq15_pkg::ACC_W-1:0]    sum_out
);

  logic signed [firq15_pkg::SAMPLE_W-1:0] data;
  logic signed [firq15_pkg::SAMPLE_W-1:0] coef;
  logic signed [firq15_pkg::ACC_W-1:0]    prod;

  // tap state: cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
      coef <= '0;
    end else begin
      if (coef_we) begin
        coef <= coef_in;
      end
      if (fill) begin
        data <= fill_value;
      end else if (load) begin
        data <= data_in;
      end
    end
  end

  // product register, held until the next filter transaction
  always_ff @(posedge clk) begin
    if (mul) begin
      prod <= coef * data;
    end
  end

  // partial sum moves to the neighbor every cycle, wrapping at 32 bits
  always_ff @(posedge clk) begin
    sum_out <= sum_in + prod;
  end

  assign data_out = data;

endmodule

`default_nettype wire

// File: src/firq15_ctrl.sv
// sequencer: accepts transactions, times the sum ripple and loads the output register
`default_nettype none

module firq15_ctrl #(
  parameter int HISTORY_LEN = 15
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [firq15_pkg::ACT_W-1:0]  action,
  output logic                               in_ready,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_load,
  output firq15_pkg::cell_ctl_t              ctl
);

  localparam int CNT_W = $clog2(HISTORY_LEN + 1);

  firq15_pkg::state_t state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               accept;
  logic               out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      firq15_pkg::ST_IDLE: begin
        if (accept && action == firq15_pkg::ACT_FILTER) begin
          state_next = firq15_pkg::ST_MUL;
        end
      end
      firq15_pkg::ST_MUL: begin
        state_next = firq15_pkg::ST_SUM;
        cnt_next   = '0;
      end
      firq15_pkg::ST_SUM: begin
        if (cnt == CNT_W'(HISTORY_LEN)) begin
          state_next = firq15_pkg::ST_DONE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      firq15_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = firq15_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = firq15_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    out_load      = 1'b0;
    ctl.head_load = 1'b0;
    ctl.shift     = 1'b0;
    ctl.mul       = 1'b0;
    ctl.fill      = 1'b0;
    case (state)
      firq15_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        ctl.head_load = in_valid && action == firq15_pkg::ACT_FILTER;
        ctl.fill      = in_valid && action == firq15_pkg::ACT_FILL;
      end
      firq15_pkg::ST_MUL: begin
        ctl.shift = 1'b1;
        ctl.mul   = 1'b1;
      end
      firq15_pkg::ST_SUM: begin
      end
      firq15_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // state, counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= firq15_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a filter transaction always starts the multiply step
  a_filter_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && action == firq15_pkg::ACT_FILTER) |=> state == firq15_pkg::ST_MUL)
    else $error("filter transaction did not start the multiply step");

  // the sum ripple ends when the counter reaches HISTORY_LEN
  a_sum_ends: assert property (@(posedge clk) disable iff (rst)
    (state == firq15_pkg::ST_SUM && cnt == CNT_W'(HISTORY_LEN))
      |=> state == firq15_pkg::ST_DONE)
    else $error("sum ripple did not end on time");

  // a finished result waits while the output register is still occupied
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == firq15_pkg::ST_DONE && out_valid && !out_ready)
      |=> state == firq15_pkg::ST_DONE)
    else $error("result dropped while output occupied");

  // in the sum state the counter never passes HISTORY_LEN
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == firq15_pkg::ST_SUM |-> cnt <= CNT_W'(HISTORY_LEN))
    else $error("sum counter out of range");

endmodule

`default_nettype wire

// File: src/fir_filter_q15.sv
// top level of the q15 fir filter: tap cell chain and sequencer
`default_nettype none

// Q15 FIR filter with HISTORY_LEN+1 taps built as a chain of tap cells, each
// holding one history sample and one coefficient. tuser selects the action:
// filter, fill history, load coefficient or none. Fill and load transactions
// are taken one per cycle while the sequencer is idle and produce no output.
// No transaction is accepted until a filter transaction is finished: cell 0
// captures the sample, all products are formed in parallel, the partial sum
// ripples through the registered adder chain, and the output register is
// loaded once it is free. The result is rounded (add 2^14, shift right 15)
// and truncated to 16 bits without saturation; the 32-bit accumulation
// wraps. Loads with coef_index above HISTORY_LEN are ignored. History and
// coefficients are zero after reset.
module fir_filter_q15 #(
  parameter int HISTORY_LEN = 15
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // sample[15:0], coef_index[19:16], coef_value[35:20], zero pad[39:36]
  input  wire logic [39:0] s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // filtered[15:0]
  output logic [15:0]      m_axis_tdata
);

  localparam int NCELLS = HISTORY_LEN + 1;
  localparam int SW     = firq15_pkg::SAMPLE_W;
  localparam int IW     = firq15_pkg::INDEX_W;
  localparam int AW     = firq15_pkg::ACC_W;

  logic signed [SW-1:0] sample;
  logic        [IW-1:0] coef_index;
  logic signed [SW-1:0] coef_value;
  logic                 load_accept;
  logic                 out_load;
  firq15_pkg::cell_ctl_t ctl;

  logic signed [SW-1:0] data_chain [NCELLS];
  logic        [AW-1:0] sum_chain  [NCELLS+1];
  logic        [AW-1:0] rounded;

  // unpack the input transaction
  assign sample     = s_axis_tdata[SW-1:0];
  assign coef_index = s_axis_tdata[SW+IW-1:SW];
  assign coef_value = s_axis_tdata[2*SW+IW-1:SW+IW];

  assign load_accept = s_axis_tvalid && s_axis_tready &&
                       s_axis_tuser == firq15_pkg::ACT_LOAD;

  firq15_ctrl #(
    .HISTORY_LEN(HISTORY_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .action   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_load (out_load),
    .ctl      (ctl)
  );

  assign sum_chain[0] = '0;

  // tap chain: cell 0 holds the new sample, cell i holds history entry i-1
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    logic signed [SW-1:0] cell_in;
    logic                 cell_load;
    logic                 cell_we;

    if (i == 0) begin : g_head
      assign cell_in   = sample;
      assign cell_load = ctl.head_load;
    end else begin : g_tail
      assign cell_in   = data_chain[i-1];
      assign cell_load = ctl.shift;
    end

    assign cell_we = load_accept && 32'(coef_index) == i;

    firq15_tap_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (cell_load),
      .fill      (ctl.fill),
      .mul       (ctl.mul),
      .coef_we   (cell_we),
      .coef_in   (coef_value),
      .data_in   (cell_in),
      .fill_value(sample),
      .sum_in    (sum_chain[i]),
      .data_out  (data_chain[i]),
      .sum_out   (sum_chain[i+1])
    );
  end

  // round and keep bits 30..15
  assign rounded = sum_chain[NCELLS] + firq15_pkg::ROUND_ADD;

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= rounded[firq15_pkg::FRAC_BITS+SW-1:firq15_pkg::FRAC_BITS];
    end
  end

endmodule

`default_nettype wire
